FILE: src/key_table_linear_interpolation_search_assert.svh
// Assertion macros for the key table search block.
`ifndef KEY_TABLE_LINEAR_INTERPOLATION_SEARCH_ASSERT_SVH
`define KEY_TABLE_LINEAR_INTERPOLATION_SEARCH_ASSERT_SVH

// same-cycle implication
`define KTLIS_CHK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTLIS_CHK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ktlis_pkg.sv
// Shared constants and types for the key table search block.
package ktlis_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_W       = 63;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SW          = CNT_W + 1;
  localparam int POS_W       = 6;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int PROD_W      = KEY_W + IDX_W;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_LINEAR = 2'd2,
    MODE_INTERP = 2'd3
  } mode_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] d;
    logic [IDX_W-1:0] r;
    logic [KEY_W-1:0] s;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] q;
  } div_rsp_t;

endpackage

FILE: src/key_table_linear_interpolation_search.sv
// Key table with linear and interpolation search: sequencer and top level.
//
// Input channel (in_valid/in_ready) carries mode and search_key. Clear and
// append give no result; an append to a full table is dropped. A linear
// search reads one stored entry per cycle while the receiver does not stall
// it, and gives one result per match (found, position, last) or one
// not-found result. An interpolation search first sorts the table with an
// exchange sort if needed, through the table memory, then each probe uses
// the quotient unit and memory reads.
// One item is worked at a time; in_ready is high only while idle.
// Results sit in an output register (out_valid/out_ready); a new item can be
// taken while the last result waits. A stalled receiver holds the search.
// Reset empties the table and marks it unsorted; no clearing pass is needed.
module key_table_linear_interpolation_search
  import ktlis_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic [KEY_W-1:0] search_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [POS_W-1:0] position,
  output logic             last
);

`include "key_table_linear_interpolation_search_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIN_CMP, ST_LIN_FIN,
    ST_S_RDI, ST_S_LDI, ST_S_CMP, ST_S_WRI,
    ST_I_CHK, ST_I_RDR, ST_I_EVAL, ST_I_DIV, ST_I_MCMP,
    ST_I_POST, ST_I_PCMP, ST_RES
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic                    sorted;
  logic [KEY_W-1:0]        key;
  logic [CNT_W-1:0]        i;
  logic [CNT_W-1:0]        j;
  logic [KEY_W-1:0]        ki;
  logic [KEY_W-1:0]        lo;
  logic signed [SW-1:0]    left;
  logic signed [SW-1:0]    right;
  logic [IDX_W-1:0]        mid;
  logic                    pend_valid;
  logic [IDX_W-1:0]        pend_pos;
  logic [RES_W-1:0]        nres;
  logic                    res_found;
  logic [IDX_W-1:0]        res_pos;

  mem_req_t                mreq;
  logic [KEY_W-1:0]        rdata;
  div_req_t                dreq;
  div_rsp_t                drsp;

  logic                    accept;
  logic                    free;
  logic                    match;
  logic                    stall;
  logic                    emit;
  logic                    lin_end;
  logic                    swap;
  logic [CNT_W-1:0]        count_m1;
  logic signed [SW-1:0]    count_s;
  logic [IDX_W-1:0]        mid_c;
  logic                    in_range;
  logic                    inc_full;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign free     = !out_valid || out_ready;
  assign match    = (rdata == key);
  assign stall    = match && pend_valid && !free;
  assign emit     = free && (((state == ST_LIN_CMP) && match && pend_valid) ||
                             (state == ST_LIN_FIN) || (state == ST_RES));
  assign count_m1 = count - CNT_W'(1);
  assign count_s  = SW'(count);
  assign lin_end  = (j == count_m1) || (match && nres == RES_W'(MAX_RESULTS - 1));
  assign swap     = ki > rdata;
  assign mid_c    = left[IDX_W-1:0] + drsp.q;
  assign in_range = (lo <= key) && (rdata >= key);
  assign inc_full = (count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    mreq       = '0;
    mreq.wdata = ki;
    dreq       = '0;
    dreq.d     = key - lo;
    dreq.r     = IDX_W'(right - left);
    dreq.s     = rdata - lo;
    unique case (state)
      ST_IDLE: begin
        mreq.waddr = count[IDX_W-1:0];
        mreq.wdata = search_key;
        mreq.we    = accept && (mode == MODE_APPEND) && !inc_full;
        mreq.re    = accept && (mode == MODE_LINEAR);
        mreq.raddr = '0;
      end
      ST_LIN_CMP: begin
        mreq.re    = !stall && !lin_end;
        mreq.raddr = IDX_W'(j + CNT_W'(1));
      end
      ST_S_RDI: begin
        mreq.re    = 1'b1;
        mreq.raddr = i[IDX_W-1:0];
      end
      ST_S_LDI: begin
        mreq.re    = 1'b1;
        mreq.raddr = IDX_W'(i + CNT_W'(1));
      end
      ST_S_CMP: begin
        mreq.we    = swap;
        mreq.waddr = j[IDX_W-1:0];
        mreq.re    = (j != count_m1);
        mreq.raddr = IDX_W'(j + CNT_W'(1));
      end
      ST_S_WRI: begin
        mreq.we    = 1'b1;
        mreq.waddr = i[IDX_W-1:0];
      end
      ST_I_CHK, ST_I_POST: begin
        mreq.re    = 1'b1;
        mreq.raddr = left[IDX_W-1:0];
      end
      ST_I_RDR: begin
        mreq.re    = 1'b1;
        mreq.raddr = right[IDX_W-1:0];
      end
      ST_I_EVAL: begin
        dreq.start = in_range && (rdata != lo);
      end
      ST_I_DIV: begin
        mreq.re    = drsp.done;
        mreq.raddr = mid_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      sorted     <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            key <= search_key;
            unique case (mode_t'(mode))
              MODE_CLEAR: begin
                count  <= '0;
                sorted <= 1'b0;
              end
              MODE_APPEND: begin
                if (!inc_full) begin
                  count  <= count + CNT_W'(1);
                  sorted <= 1'b0;
                end
              end
              MODE_LINEAR: begin
                j          <= '0;
                nres       <= '0;
                pend_valid <= 1'b0;
                state      <= (count == '0) ? ST_LIN_FIN : ST_LIN_CMP;
              end
              MODE_INTERP: begin
                left      <= '0;
                right     <= count_s - SW'(1);
                i         <= '0;
                res_found <= 1'b0;
                res_pos   <= '0;
                if (count == '0) begin
                  state <= ST_RES;
                end else if (sorted) begin
                  state <= ST_I_CHK;
                end else begin
                  state <= ST_S_RDI;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LIN_CMP: begin
          if (!stall) begin
            if (match) begin
              if (pend_valid) begin
                out_valid <= 1'b1;
                found     <= 1'b1;
                position  <= POS_W'(pend_pos);
                last      <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_pos   <= j[IDX_W-1:0];
              nres       <= nres + RES_W'(1);
            end
            if (lin_end) begin
              state <= ST_LIN_FIN;
            end else begin
              j <= j + CNT_W'(1);
            end
          end
        end
        ST_LIN_FIN: begin
          if (free) begin
            out_valid <= 1'b1;
            found     <= pend_valid;
            position  <= pend_valid ? POS_W'(pend_pos) : '0;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_S_RDI: begin
          state <= ST_S_LDI;
        end
        ST_S_LDI: begin
          ki <= rdata;
          j  <= i + CNT_W'(1);
          state <= ((i + CNT_W'(1)) >= count) ? ST_S_WRI : ST_S_CMP;
        end
        ST_S_CMP: begin
          if (swap) begin
            ki <= rdata;
          end
          if (j == count_m1) begin
            state <= ST_S_WRI;
          end else begin
            j <= j + CNT_W'(1);
          end
        end
        ST_S_WRI: begin
          if ((SW'(i) + SW'(2)) >= count_s) begin
            sorted <= 1'b1;
            state  <= ST_I_CHK;
          end else begin
            i     <= i + CNT_W'(1);
            state <= ST_S_RDI;
          end
        end
        ST_I_CHK: begin
          state <= (left <= right) ? ST_I_RDR : ST_I_POST;
        end
        ST_I_RDR: begin
          lo    <= rdata;
          state <= ST_I_EVAL;
        end
        ST_I_EVAL: begin
          if (!in_range) begin
            state <= ST_I_POST;
          end else if (rdata == lo) begin
            res_found <= 1'b1;
            res_pos   <= left[IDX_W-1:0];
            state     <= ST_RES;
          end else begin
            state <= ST_I_DIV;
          end
        end
        ST_I_DIV: begin
          if (drsp.done) begin
            mid   <= mid_c;
            state <= ST_I_MCMP;
          end
        end
        ST_I_MCMP: begin
          if (rdata < key) begin
            left  <= SW'(mid) + SW'(1);
            state <= ST_I_CHK;
          end else if (rdata > key) begin
            right <= SW'(mid) - SW'(1);
            state <= ST_I_CHK;
          end else begin
            res_found <= 1'b1;
            res_pos   <= mid;
            state     <= ST_RES;
          end
        end
        ST_I_POST: begin
          state <= (left < count_s) ? ST_I_PCMP : ST_RES;
        end
        ST_I_PCMP: begin
          res_found <= match;
          res_pos   <= match ? left[IDX_W-1:0] : '0;
          state     <= ST_RES;
        end
        ST_RES: begin
          if (free) begin
            out_valid <= 1'b1;
            found     <= res_found;
            position  <= POS_W'(res_pos);
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  ktlis_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  ktlis_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  `KTLIS_CHK_NOW(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH),
    "entry count beyond table depth")
  `KTLIS_CHK_NEXT(a_append_grows, accept && mode == MODE_APPEND && !inc_full,
    count == $past(count) + CNT_W'(1), "append did not grow the table")
  `KTLIS_CHK_NOW(a_div_in_seq, drsp.done, state == ST_I_DIV,
    "quotient finished outside a probe")
  `KTLIS_CHK_NOW(a_sorted_empty, state == ST_I_CHK, sorted,
    "probe started on an unsorted table")

endmodule

FILE: src/ktlis_mem.sv
// Key storage: one write port, one registered read port.
module ktlis_mem
  import ktlis_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] keys [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      keys[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= keys[req.raddr];
    end
  end

endmodule

FILE: src/ktlis_div.sv
// Iterative scaled quotient unit: floor(d * r / s), one quotient bit per cycle.
module ktlis_div
  import ktlis_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              running;
  logic              done;
  logic [CNT_W-1:0]  steps;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic [IDX_W-1:0]  q;
  logic              take;
  logic [PROD_W-1:0] diff;

  assign take = rem >= dsh;
  assign diff = rem - dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        rem     <= PROD_W'(req.d) * PROD_W'(req.r);
        dsh     <= PROD_W'(req.s) << (IDX_W - 1);
        steps   <= CNT_W'(IDX_W);
        q       <= '0;
      end else if (running) begin
        if (take) begin
          rem <= diff;
        end
        dsh   <= dsh >> 1;
        q     <= IDX_W'({q, take});
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = q;

endmodule

FILE: sim/tb_key_table_linear_interpolation_search.sv
// Testbench for the key table search block: queued stimulus, predicted results, field checks.
module tb_key_table_linear_interpolation_search;
  import ktlis_pkg::*;

  typedef struct packed {
    mode_t            op;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic             fin;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       mode = MODE_CLEAR;
  logic [KEY_W-1:0] search_key = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             found;
  logic [POS_W-1:0] position;
  logic             last;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [KEY_W-1:0] keys[TABLE_DEPTH];
  int  key_count = 0;
  bit  keys_sorted = 0;
  int  mismatch_count = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  calm = 0;
  bit  hold_input = 0;
  bit  long_hold = 0;

  key_table_linear_interpolation_search uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .search_key(search_key), .out_valid(out_valid),
    .out_ready(out_ready), .found(found), .position(position), .last(last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic logic [IDX_W-1:0] probe_offset(input logic [KEY_W-1:0] d,
      input int r, input logic [KEY_W-1:0] s);
    logic [PROD_W+1:0] prod;
    prod = {2'b0, d} * r;
    return IDX_W'(prod / s);
  endfunction

  task automatic predict_search(input request_t req);
    int n;
    int lo;
    int hi;
    int mid;
    int hit;
    logic [KEY_W-1:0] t;
    n = 0;
    if (req.op == MODE_CLEAR) begin
      key_count = 0;
      keys_sorted = 0;
    end else if (req.op == MODE_APPEND) begin
      if (key_count < TABLE_DEPTH) begin
        keys[key_count] = req.key;
        key_count++;
        keys_sorted = 0;
      end
    end else if (req.op == MODE_LINEAR) begin
      for (int i = 0; i < key_count && n < MAX_RESULTS; i++) begin
        if (keys[i] == req.key) begin
          expected_answers.push_back('{1'b1, POS_W'(i), 1'b0});
          n++;
        end
      end
      if (n == 0) expected_answers.push_back('{1'b0, '0, 1'b1});
      else expected_answers[$].fin = 1'b1;
    end else if (key_count == 0) begin
      expected_answers.push_back('{1'b0, '0, 1'b1});
    end else begin
      if (!keys_sorted) begin
        for (int i = 0; i < key_count; i++)
          for (int j = i + 1; j < key_count; j++)
            if (keys[i] > keys[j]) begin
              t = keys[i];
              keys[i] = keys[j];
              keys[j] = t;
            end
        keys_sorted = 1;
      end
      lo = 0;
      hi = key_count - 1;
      hit = -1;
      while (lo <= hi && keys[lo] <= req.key && keys[hi] >= req.key) begin
        if (keys[hi] == keys[lo]) begin
          hit = lo;
          break;
        end
        mid = lo + probe_offset(req.key - keys[lo], hi - lo, keys[hi] - keys[lo]);
        if (keys[mid] < req.key) lo = mid + 1;
        else if (keys[mid] > req.key) hi = mid - 1;
        else begin
          hit = mid;
          break;
        end
      end
      if (hit < 0 && lo >= 0 && lo < key_count && keys[lo] == req.key) hit = lo;
      if (hit < 0) expected_answers.push_back('{1'b0, '0, 1'b1});
      else expected_answers.push_back('{1'b1, POS_W'(hit), 1'b1});
    end
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom(), $urandom()});
  endfunction

  task automatic add(input mode_t op, input logic [KEY_W-1:0] key);
    pending_reqs.push_back('{op, key});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid && in_ready) predict_search('{mode_t'(mode), search_key});
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0 && !(in_valid && in_ready)) begin
        in_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_input) begin
        in_valid <= 1'b1;
        mode <= pending_reqs[0].op;
        search_key <= pending_reqs[0].key;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          report("unexpected transfer", position, 0);
        end else begin
          if (found !== expected_answers[0].hit) report("found", found, expected_answers[0].hit);
          if (position !== expected_answers[0].pos)
            report("position", position, expected_answers[0].pos);
          if (last !== expected_answers[0].fin) report("last", last, expected_answers[0].fin);
          void'(expected_answers.pop_front());
        end
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] base;
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add(MODE_LINEAR, '0);
    add(MODE_INTERP, '1);
    add(MODE_APPEND, '1);
    add(MODE_APPEND, '0);
    add(MODE_APPEND, 63'h2AAA_AAAA_AAAA_AAAA);
    add(MODE_APPEND, 63'h5555_5555_5555_5555);
    add(MODE_APPEND, '0);
    add(MODE_LINEAR, '0);
    add(MODE_LINEAR, '1);
    add(MODE_LINEAR, 63'd7);
    add(MODE_INTERP, 63'h5555_5555_5555_5555);
    add(MODE_INTERP, '1);
    add(MODE_INTERP, 63'd3);
    add(MODE_CLEAR, '0);
    for (int i = 0; i < 4; i++) add(MODE_APPEND, 63'd9);
    add(MODE_INTERP, 63'd9);
    add(MODE_INTERP, 63'd8);
    add(MODE_LINEAR, 63'd9);
    drain();

    // fill past capacity with equal keys, hold the receiver while input continues
    add(MODE_CLEAR, '0);
    for (int i = 0; i < TABLE_DEPTH + 2; i++) add(MODE_APPEND, 63'd5);
    add(MODE_LINEAR, 63'd5);
    add(MODE_LINEAR, 63'd5);
    add(MODE_INTERP, 63'd5);
    long_hold = 1;
    repeat (400) @(posedge clk);
    long_hold = 0;
    drain();

    sent = 0;
    while (sent < 50) begin
      base = $urandom_range(0, 3) == 0 ? rand_key() : KEY_W'($urandom_range(0, 40));
      add(MODE_CLEAR, '0);
      for (int i = $urandom_range(0, 20); i > 0; i--) begin
        if ($urandom_range(0, 3) == 0) add(MODE_APPEND, rand_key());
        else add(MODE_APPEND, base + KEY_W'($urandom_range(0, 30)));
        sent++;
      end
      for (int i = $urandom_range(1, 6); i > 0; i--) begin
        add($urandom_range(0, 1) ? MODE_LINEAR : MODE_INTERP,
            $urandom_range(0, 5) == 0 ? rand_key() : base + KEY_W'($urandom_range(0, 30)));
        if ($urandom_range(0, 9) == 0) add(MODE_APPEND, base + KEY_W'($urandom_range(0, 30)));
        sent++;
      end
      if (sent > 35) calm = 1;
      if ($urandom_range(0, 5) == 0) begin
        hold_input = 1;
        @(posedge clk);
        while (in_valid) @(posedge clk);
        while (expected_answers.size() > 0) @(posedge clk);
        hold_input = 0;
      end
    end
    drain();

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/ktlis_pkg.sv
src/ktlis_mem.sv
src/ktlis_div.sv
src/key_table_linear_interpolation_search.sv
sim/tb_key_table_linear_interpolation_search.sv
